/* hw/rtl/gss_pkg.sv */
package gss_pkg;

  // Mode codes of an input transaction.
  localparam logic [1:0] MODE_SPLAT = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_WIDTH    = 2'd0;
  localparam logic [1:0] REG_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_AMP_GAIN = 2'd2;
  localparam logic [1:0] REG_DEV_GAIN = 2'd3;

  localparam logic [15:0] AMP_THRESHOLD = 16'd3277;
  localparam logic [15:0] Q16_MAX       = 16'hFFFF;

  // Signed pixel coordinate width; covers a window reaching past either edge.
  localparam int CRD_W = 12;

  localparam int DIV_STEPS = 20;
  localparam int TERMS     = 12;
  localparam int SQUARINGS = 4;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SCALE,
    CMD_WINDOW,
    CMD_PIX,
    CMD_DIV,
    CMD_MUL,
    CMD_REC,
    CMD_FIX,
    CMD_SQ,
    CMD_AMP,
    CMD_WRITE,
    CMD_READ,
    CMD_RCAP,
    CMD_CLR_STEP
  } cmd_t;

  typedef struct packed {
    logic below;
    logic empty;
    logic div_last;
    logic term_last;
    logic sq_last;
    logic flat;
    logic pix_last;
    logic clr_last;
  } stat_t;

  // floor(2^32 / k) for the series terms; k of one bypasses the multiply.
  function automatic logic [31:0] recip(input logic [3:0] k);
    logic [31:0] r;
    case (k)
      4'd2:    r = 32'h8000_0000;
      4'd3:    r = 32'h5555_5555;
      4'd4:    r = 32'h4000_0000;
      4'd5:    r = 32'h3333_3333;
      4'd6:    r = 32'h2AAA_AAAA;
      4'd7:    r = 32'h2492_4924;
      4'd8:    r = 32'h2000_0000;
      4'd9:    r = 32'h1C71_C71C;
      4'd10:   r = 32'h1999_9999;
      4'd11:   r = 32'h1745_D174;
      4'd12:   r = 32'h1555_5555;
      default: r = 32'hFFFF_FFFF;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/gss_ctrl.sv */
module gss_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [1:0]     mode,
  input  gss_pkg::stat_t stat,
  output gss_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           done
);

  typedef enum logic [4:0] {
    S_INIT_CLR,
    S_IDLE,
    S_SCALE,
    S_THR,
    S_WINDOW,
    S_CHECK,
    S_PIX,
    S_DIV,
    S_MUL,
    S_REC,
    S_FIX,
    S_SQ,
    S_AMP,
    S_WRITE,
    S_READ,
    S_RCAP,
    S_CLEAR,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = gss_pkg::CMD_NONE;
    unique case (state)
      S_INIT_CLR: begin
        cmd = gss_pkg::CMD_CLR_STEP;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd = gss_pkg::CMD_LOAD;
          unique case (mode)
            gss_pkg::MODE_SPLAT: state_next = S_SCALE;
            gss_pkg::MODE_READ:  state_next = S_READ;
            gss_pkg::MODE_CLEAR: state_next = S_CLEAR;
            default:             state_next = S_DONE;
          endcase
        end
      end
      S_SCALE: begin
        cmd        = gss_pkg::CMD_SCALE;
        state_next = S_THR;
      end
      S_THR: state_next = stat.below ? S_DONE : S_WINDOW;
      S_WINDOW: begin
        cmd        = gss_pkg::CMD_WINDOW;
        state_next = S_CHECK;
      end
      S_CHECK: state_next = stat.empty ? S_DONE : S_PIX;
      S_PIX: begin
        cmd        = gss_pkg::CMD_PIX;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd = gss_pkg::CMD_DIV;
        if (stat.div_last) state_next = stat.flat ? S_AMP : S_MUL;
      end
      S_MUL: begin
        cmd        = gss_pkg::CMD_MUL;
        state_next = S_REC;
      end
      S_REC: begin
        cmd        = gss_pkg::CMD_REC;
        state_next = S_FIX;
      end
      S_FIX: begin
        cmd        = gss_pkg::CMD_FIX;
        state_next = stat.term_last ? S_SQ : S_MUL;
      end
      S_SQ: begin
        cmd = gss_pkg::CMD_SQ;
        if (stat.sq_last) state_next = S_AMP;
      end
      S_AMP: begin
        cmd        = gss_pkg::CMD_AMP;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd        = gss_pkg::CMD_WRITE;
        state_next = stat.pix_last ? S_DONE : S_PIX;
      end
      S_READ: begin
        cmd        = gss_pkg::CMD_READ;
        state_next = S_RCAP;
      end
      S_RCAP: begin
        cmd        = gss_pkg::CMD_RCAP;
        state_next = S_DONE;
      end
      S_CLEAR: begin
        cmd = gss_pkg::CMD_CLR_STEP;
        if (stat.clr_last) state_next = S_DONE;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT_CLR;
      busy  <= 1'b1;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
      done  <= (state_next == S_DONE);
    end
  end

endmodule

/* hw/rtl/gss_dp.sv */
module gss_dp #(
  parameter int MAX_DIM = 512
) (
  input  logic           clk,
  input  logic           rst,
  input  gss_pkg::cmd_t  cmd,
  output gss_pkg::stat_t stat,
  input  logic           cfg_write,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_data,
  input  logic [1:0]     tile_col,
  input  logic [1:0]     tile_row,
  input  logic [3:0]     cell_u,
  input  logic [3:0]     cell_v,
  input  logic [15:0]    amp_raw,
  input  logic [15:0]    offset_a_raw,
  input  logic [15:0]    offset_b_raw,
  input  logic [15:0]    spread_a_raw,
  input  logic [15:0]    spread_b_raw,
  input  logic [8:0]     read_x,
  input  logic [8:0]     read_y,
  output logic [15:0]    pixel_value,
  output logic           star_drawn,
  output logic [9:0]     pixels_touched
);

  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int AW      = $clog2(DEPTH);
  localparam int DIM_CAP = (MAX_DIM < 1024) ? MAX_DIM : 1023;
  localparam logic [9:0]  DIM_CAP_V = 10'(DIM_CAP);
  localparam logic [12:0] DIM_V     = 13'(MAX_DIM);
  localparam int CW = gss_pkg::CRD_W;

  logic [15:0] mem [DEPTH];

  // Configuration.
  logic [9:0]  img_w, img_h;
  logic [15:0] amp_gain, dev_gain;

  // Captured item.
  logic [1:0]  tcol, trow;
  logic [3:0]  cu, cv;
  logic [15:0] amp_r, offa, offb, spa, spb;
  logic [8:0]  rx, ry;

  logic [15:0] amp, sa, sb;
  logic signed [CW-1:0] xc, yc, x0, x1, y0, y1, xq, yq;
  logic [20:0] den;
  logic [21:0] rem;
  logic [19:0] q;
  logic        e_zero, e_big;
  logic [4:0]  div_cnt;
  logic [3:0]  kk;
  logic [1:0]  sq_cnt;
  logic [32:0] t;
  logic [31:0] p, q0;
  logic [33:0] yacc;
  logic [15:0] g;
  logic [AW-1:0] clr_cnt;
  logic [15:0] rdata;
  logic        rd_ok;

  // Gain scaling.
  logic [31:0] amp_p, sa_p, sb_p;
  logic [15:0] amp_n, sa_n, sb_n;

  always_comb begin
    amp_p = amp_r * amp_gain;
    sa_p  = spa * dev_gain;
    sb_p  = spb * dev_gain;
    amp_n = (amp_p[31:28] != 4'd0) ? gss_pkg::Q16_MAX : amp_p[27:12];
    sa_n  = (sa_p[31:28] != 4'd0) ? gss_pkg::Q16_MAX : sa_p[27:12];
    sb_n  = (sb_p[31:28] != 4'd0) ? gss_pkg::Q16_MAX : sb_p[27:12];
  end

  // Window setup.
  logic [15:0] smax;
  logic [16:0] ssum;
  logic [20:0] vscale;
  logic [2:0]  kval;
  logic [4:0]  half;
  logic [8:0]  xc9, yc9;
  logic [9:0]  w10, h10;
  logic signed [CW-1:0] xcs, ycs, hs, xlo, xhi, ylo, yhi, x0n, x1n, y0n, y1n, nxs, nys;
  logic [4:0]  nx, ny;

  always_comb begin
    smax   = (sa > sb) ? sa : sb;
    ssum   = {1'b0, sa} + {1'b0, sb};
    vscale = 21'({5'd0, smax} * 21'd24);
    // Ceiling of the root: count the squares that still fall short.
    kval = 3'd0;
    for (int j = 0; j < 5; j++) begin
      if (vscale > 21'(j * j * 65536)) kval = kval + 3'd1;
    end
    half = 5'({2'd0, kval} * 5'd3);
    xc9  = {tcol, 7'd0} + {2'd0, cu, 3'd0} + {6'd0, offb[15:13]};
    yc9  = {trow, 7'd0} + {2'd0, cv, 3'd0} + {6'd0, offa[15:13]};
    w10  = (img_w < DIM_CAP_V) ? img_w : DIM_CAP_V;
    h10  = (img_h < DIM_CAP_V) ? img_h : DIM_CAP_V;
    xcs  = $signed({3'd0, xc9});
    ycs  = $signed({3'd0, yc9});
    hs   = $signed({7'd0, half});
    xlo  = xcs - hs;
    xhi  = xcs + hs;
    ylo  = ycs - hs;
    yhi  = ycs + hs;
    x0n  = (xlo < 0) ? '0 : xlo;
    y0n  = (ylo < 0) ? '0 : ylo;
    x1n  = (xhi < $signed({2'd0, w10})) ? xhi : $signed({2'd0, w10});
    y1n  = (yhi < $signed({2'd0, h10})) ? yhi : $signed({2'd0, h10});
    nxs  = x1n - x0n;
    nys  = y1n - y0n;
    nx   = (x1n > x0n) ? nxs[4:0] : 5'd0;
    ny   = (y1n > y0n) ? nys[4:0] : 5'd0;
  end

  // Per-pixel distance and divider.
  logic signed [CW-1:0] dx, dy, dxx, dyy, r2f;
  logic [8:0]  r2;
  logic [20:0] r2sh;
  logic [21:0] rem2;
  logic        qbit;

  always_comb begin
    dx   = xq - xc;
    dy   = yq - yc;
    dxx  = dx * dx;
    dyy  = dy * dy;
    r2f  = dxx + dyy;
    r2   = r2f[8:0];
    r2sh = {r2, 12'd0};
    rem2 = {rem[20:0], 1'b0};
    qbit = (rem2 >= {1'b0, den});
  end

  // Series, squaring and amplitude products.
  logic [31:0] xval, sq_op;
  logic [63:0] pm, rm, sqp;
  logic [35:0] qk, rr;
  logic [31:0] tn;
  logic [47:0] ap;

  always_comb begin
    xval  = {q, 12'd0};
    pm    = t[31:0] * xval;
    rm    = p * gss_pkg::recip(kk);
    qk    = q0 * kk;
    rr    = {4'd0, p} - qk;
    tn    = (rr >= {32'd0, kk}) ? q0 + 32'd1 : q0;
    sq_op = (yacc[33:32] != 2'd0) ? 32'hFFFF_FFFF : yacc[31:0];
    sqp   = sq_op * sq_op;
    ap    = amp * yacc[31:0];
  end

  // Store port.
  logic [AW-1:0] pix_addr, rd_addr, mem_addr;
  logic [16:0]   sum17;
  logic [15:0]   mem_wdata;
  logic          mem_we, mem_re;

  always_comb begin
    pix_addr  = AW'(AW'(yq[9:0]) * AW'(MAX_DIM)) + AW'(xq[9:0]);
    rd_addr   = AW'(AW'(ry) * AW'(MAX_DIM)) + AW'(rx);
    sum17     = {1'b0, rdata} + {1'b0, g};
    mem_we    = (cmd == gss_pkg::CMD_CLR_STEP) || (cmd == gss_pkg::CMD_WRITE);
    mem_re    = (cmd == gss_pkg::CMD_READ) || (cmd == gss_pkg::CMD_PIX);
    mem_wdata = '0;
    mem_addr  = pix_addr;
    if (cmd == gss_pkg::CMD_CLR_STEP) begin
      mem_addr = clr_cnt;
    end else if (cmd == gss_pkg::CMD_READ) begin
      mem_addr = rd_addr;
    end else begin
      mem_wdata = sum17[16] ? gss_pkg::Q16_MAX : sum17[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end else if (mem_re) begin
      rdata <= mem[mem_addr];
    end
  end

  always_comb begin
    stat.below     = (amp < gss_pkg::AMP_THRESHOLD);
    stat.empty     = (x1 <= x0) || (y1 <= y0);
    stat.div_last  = (div_cnt == 5'(gss_pkg::DIV_STEPS - 1));
    stat.term_last = (kk == 4'(gss_pkg::TERMS));
    stat.sq_last   = (sq_cnt == 2'(gss_pkg::SQUARINGS - 1));
    stat.flat      = e_zero || e_big;
    stat.pix_last  = (xq == x1 - 1) && (yq == y1 - 1);
    stat.clr_last  = (clr_cnt == AW'(DEPTH - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      img_w    <= 10'd512;
      img_h    <= 10'd512;
      amp_gain <= 16'd4096;
      dev_gain <= 16'd4096;
      clr_cnt  <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          gss_pkg::REG_WIDTH:    img_w    <= cfg_data[9:0];
          gss_pkg::REG_HEIGHT:   img_h    <= cfg_data[9:0];
          gss_pkg::REG_AMP_GAIN: amp_gain <= cfg_data;
          gss_pkg::REG_DEV_GAIN: dev_gain <= cfg_data;
          default: ;
        endcase
      end
      if (cmd == gss_pkg::CMD_LOAD) begin
        clr_cnt <= '0;
      end else if (cmd == gss_pkg::CMD_CLR_STEP) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd)
      gss_pkg::CMD_LOAD: begin
        tcol           <= tile_col;
        trow           <= tile_row;
        cu             <= cell_u;
        cv             <= cell_v;
        amp_r          <= amp_raw;
        offa           <= offset_a_raw;
        offb           <= offset_b_raw;
        spa            <= spread_a_raw;
        spb            <= spread_b_raw;
        rx             <= read_x;
        ry             <= read_y;
        pixel_value    <= '0;
        star_drawn     <= 1'b0;
        pixels_touched <= '0;
      end
      gss_pkg::CMD_SCALE: begin
        amp        <= amp_n;
        sa         <= sa_n;
        sb         <= sb_n;
        star_drawn <= (amp_n >= gss_pkg::AMP_THRESHOLD);
      end
      gss_pkg::CMD_WINDOW: begin
        xc             <= xcs;
        yc             <= ycs;
        x0             <= x0n;
        x1             <= x1n;
        y0             <= y0n;
        y1             <= y1n;
        xq             <= x0n;
        yq             <= y0n;
        den            <= 21'({4'd0, ssum} * 21'd12);
        pixels_touched <= 10'(nx) * 10'(ny);
      end
      gss_pkg::CMD_PIX: begin
        rem     <= {1'b0, r2sh};
        q       <= '0;
        e_zero  <= (r2 == 9'd0);
        e_big   <= (r2sh >= den);
        div_cnt <= '0;
        kk      <= 4'd1;
        sq_cnt  <= '0;
        t       <= {1'b1, 32'd0};
        yacc    <= {2'b01, 32'd0};
      end
      gss_pkg::CMD_DIV: begin
        rem     <= qbit ? rem2 - {1'b0, den} : rem2;
        q       <= {q[18:0], qbit};
        div_cnt <= div_cnt + 5'd1;
      end
      gss_pkg::CMD_MUL: p <= t[32] ? xval : pm[63:32];
      gss_pkg::CMD_REC: q0 <= (kk == 4'd1) ? p : rm[63:32];
      gss_pkg::CMD_FIX: begin
        t    <= {1'b0, tn};
        yacc <= kk[0] ? yacc - {2'd0, tn} : yacc + {2'd0, tn};
        kk   <= kk + 4'd1;
      end
      gss_pkg::CMD_SQ: begin
        yacc   <= {2'd0, sqp[63:32]};
        sq_cnt <= sq_cnt + 2'd1;
      end
      gss_pkg::CMD_AMP: begin
        if (e_zero) g <= amp;
        else if (e_big) g <= '0;
        else g <= ap[47:32];
      end
      gss_pkg::CMD_WRITE: begin
        // Rows run inside columns.
        if (yq == y1 - 1) begin
          yq <= y0;
          xq <= xq + CW'(1);
        end else begin
          yq <= yq + CW'(1);
        end
      end
      gss_pkg::CMD_READ: rd_ok <= (13'(rx) < DIM_V) && (13'(ry) < DIM_V);
      gss_pkg::CMD_RCAP: pixel_value <= rd_ok ? rdata : 16'd0;
      default: ;
    endcase
  end

endmodule

/* hw/rtl/gaussian_star_splat.sv */
// Gaussian star splat into a saturating Q0.16 pixel store.
//
// An item is taken when start is high and busy is low. mode selects a splat,
// a single pixel read or a clear of the whole store. Exactly one result comes
// back per item: done is high for one cycle with pixel_value, star_drawn and
// pixels_touched valid in that cycle. The receiver cannot stall; results are
// simply taken when done is high.
// A drawn splat runs its setup, then one pass per window pixel through a restoring
// divider, a 12-term series, 4 squarings, the amplitude product and the write,
// and then finishes; the centre or a pixel whose weight is zero skips the series
// and the squarings. A full window is 30 by 30 pixels; one item is in work at a time.
// After reset all MAX_DIM*MAX_DIM entries of the store are cleared, one entry a cycle,
// while busy is high. Configuration writes are taken at any time but belong
// between items.
module gaussian_star_splat #(
  parameter int MAX_DIM = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic [1:0]  mode,
  input  logic [1:0]  tile_col,
  input  logic [1:0]  tile_row,
  input  logic [3:0]  cell_u,
  input  logic [3:0]  cell_v,
  input  logic [15:0] amp_raw,
  input  logic [15:0] offset_a_raw,
  input  logic [15:0] offset_b_raw,
  input  logic [15:0] spread_a_raw,
  input  logic [15:0] spread_b_raw,
  input  logic [8:0]  read_x,
  input  logic [8:0]  read_y,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic [15:0] pixel_value,
  output logic        star_drawn,
  output logic [9:0]  pixels_touched
);

  gss_pkg::cmd_t  cmd;
  gss_pkg::stat_t stat;

  gss_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .mode (mode),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy),
    .done (done)
  );

  gss_dp #(
    .MAX_DIM(MAX_DIM)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .tile_col      (tile_col),
    .tile_row      (tile_row),
    .cell_u        (cell_u),
    .cell_v        (cell_v),
    .amp_raw       (amp_raw),
    .offset_a_raw  (offset_a_raw),
    .offset_b_raw  (offset_b_raw),
    .spread_a_raw  (spread_a_raw),
    .spread_b_raw  (spread_b_raw),
    .read_x        (read_x),
    .read_y        (read_y),
    .pixel_value   (pixel_value),
    .star_drawn    (star_drawn),
    .pixels_touched(pixels_touched)
  );

endmodule

/* dv/tb_gaussian_star_splat.sv */
module tb_gaussian_star_splat;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int DIM = 512;

  typedef struct {
    logic [1:0]  mode;
    logic [1:0]  tile_col;
    logic [1:0]  tile_row;
    logic [3:0]  cell_u;
    logic [3:0]  cell_v;
    logic [15:0] amp_raw;
    logic [15:0] offset_a_raw;
    logic [15:0] offset_b_raw;
    logic [15:0] spread_a_raw;
    logic [15:0] spread_b_raw;
    logic [8:0]  read_x;
    logic [8:0]  read_y;
  } splat_cmd_t;

  typedef struct {
    logic [15:0] pixel_value;
    logic        star_drawn;
    logic [9:0]  pixels_touched;
  } splat_res_t;

  class splat_scoreboard;
    bit [15:0]  mask [DIM*DIM];
    bit [9:0]   img_w;
    bit [9:0]   img_h;
    bit [15:0]  amp_gain;
    bit [15:0]  dev_gain;
    splat_res_t expected_q [$];
    int         errors;
    int         n_checked;
    int         n_drawn;
    int         n_pixels;
    int         n_nonzero_reads;

    function new();
      foreach (mask[i]) mask[i] = '0;
      img_w = 10'd512;
      img_h = 10'd512;
      amp_gain = 16'd4096;
      dev_gain = 16'd4096;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        gss_pkg::REG_WIDTH:    img_w = data[9:0];
        gss_pkg::REG_HEIGHT:   img_h = data[9:0];
        gss_pkg::REG_AMP_GAIN: amp_gain = data;
        gss_pkg::REG_DEV_GAIN: dev_gain = data;
        default: ;
      endcase
    endfunction

    function bit [15:0] scale_clamp(bit [15:0] raw, bit [15:0] gain);
      bit [63:0] p;
      p = (64'(raw) * 64'(gain)) >> 12;
      return (p > 64'hFFFF) ? 16'hFFFF : p[15:0];
    endfunction

    // amp * exp(-e) with e in Q16.16: series for exp(-e/16), then squared four times.
    function bit [15:0] falloff(bit [15:0] amp, bit [63:0] e);
      bit [63:0] x;
      bit [63:0] t;
      bit [63:0] y;
      bit [63:0] g;
      if (e == 0) return amp;
      if (e >= (64'd16 << 16)) return 16'd0;
      x = e << 12;
      t = 64'd1 << 32;
      y = t;
      for (int k = 1; k <= 12; k++) begin
        t = ((t * x) >> 32) / 64'(k);
        if (k % 2 == 1) y = y - t;
        else y = y + t;
      end
      if (y > 64'hFFFF_FFFF) y = 64'hFFFF_FFFF;
      for (int i = 0; i < 4; i++) y = (y * y) >> 32;
      g = (64'(amp) * y) >> 32;
      return g[15:0];
    endfunction

    function void note(splat_cmd_t c);
      splat_res_t r;
      bit [15:0] amp;
      bit [15:0] sa;
      bit [15:0] sb;
      bit [15:0] smax;
      bit [63:0] ssum;
      bit [63:0] r2;
      bit [63:0] e;
      bit [16:0] acc;
      int xc, yc, k, half, w, h, x0, x1, y0, y1, dx, dy, cnt;
      r = '{default: '0};
      if (c.mode == gss_pkg::MODE_READ) begin
        r.pixel_value = mask[int'(c.read_y) * DIM + int'(c.read_x)];
        if (r.pixel_value != 0) n_nonzero_reads++;
      end else if (c.mode == gss_pkg::MODE_CLEAR) begin
        foreach (mask[i]) mask[i] = '0;
      end else if (c.mode == gss_pkg::MODE_SPLAT) begin
        amp = scale_clamp(c.amp_raw, amp_gain);
        if (amp >= gss_pkg::AMP_THRESHOLD) begin
          r.star_drawn = 1'b1;
          n_drawn++;
          sa = scale_clamp(c.spread_a_raw, dev_gain);
          sb = scale_clamp(c.spread_b_raw, dev_gain);
          smax = (sa > sb) ? sa : sb;
          ssum = 64'(sa) + 64'(sb);
          xc = int'(c.tile_col) * 128 + int'(c.cell_u) * 8 + int'(c.offset_b_raw >> 13);
          yc = int'(c.tile_row) * 128 + int'(c.cell_v) * 8 + int'(c.offset_a_raw >> 13);
          k = 0;
          while (64'(k) * 64'(k) * 64'd65536 < 64'd24 * 64'(smax)) k++;
          half = 3 * k;
          w = (img_w < DIM) ? int'(img_w) : DIM;
          h = (img_h < DIM) ? int'(img_h) : DIM;
          x0 = (xc - half < 0) ? 0 : xc - half;
          x1 = (xc + half < w) ? xc + half : w;
          y0 = (yc - half < 0) ? 0 : yc - half;
          y1 = (yc + half < h) ? yc + half : h;
          cnt = 0;
          if (ssum != 0) begin
            for (int x = x0; x < x1; x++) begin
              for (int y = y0; y < y1; y++) begin
                dx = x - xc;
                dy = y - yc;
                r2 = 64'(dx * dx + dy * dy);
                e = (r2 << 32) / (64'd12 * ssum);
                acc = 17'(mask[y * DIM + x]) + 17'(falloff(amp, e));
                mask[y * DIM + x] = acc[16] ? 16'hFFFF : acc[15:0];
                cnt++;
              end
            end
          end
          n_pixels += cnt;
          r.pixels_touched = cnt[9:0];
        end
      end
      expected_q.push_back(r);
    endfunction

    task report(string what, int got, int want);
      errors++;
      if (errors <= 40)
        $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    endtask

    task check(logic [15:0] pv, logic sd, logic [9:0] pt);
      splat_res_t w;
      if (expected_q.size() == 0) begin
        report("unexpected result", int'(pv), -1);
      end else begin
        w = expected_q.pop_front();
        n_checked++;
        if (pv !== w.pixel_value) report("pixel_value", int'(pv), int'(w.pixel_value));
        if (sd !== w.star_drawn) report("star_drawn", int'(sd), int'(w.star_drawn));
        if (pt !== w.pixels_touched)
          report("pixels_touched", int'(pt), int'(w.pixels_touched));
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        done;
  logic [1:0]  mode;
  logic [1:0]  tile_col;
  logic [1:0]  tile_row;
  logic [3:0]  cell_u;
  logic [3:0]  cell_v;
  logic [15:0] amp_raw;
  logic [15:0] offset_a_raw;
  logic [15:0] offset_b_raw;
  logic [15:0] spread_a_raw;
  logic [15:0] spread_b_raw;
  logic [8:0]  read_x;
  logic [8:0]  read_y;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic [15:0] pixel_value;
  logic        star_drawn;
  logic [9:0]  pixels_touched;

  splat_scoreboard sb;
  int n_sent;
  int last_x;
  int last_y;
  bit no_idle;

  gaussian_star_splat dut (.*);

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    if (!rst && done && sb != null) sb.check(pixel_value, star_drawn, pixels_touched);
  end

  initial begin
    #500_000_000;
    $display("tb_gaussian_star_splat: errors");
    $finish;
  end

  function automatic splat_cmd_t mk_splat(int tc, int tr, int cu, int cv, int amp,
                                          int oa, int ob, int sa, int sbr);
    splat_cmd_t c;
    c = '{default: '0};
    c.mode = gss_pkg::MODE_SPLAT;
    c.tile_col = 2'(tc);
    c.tile_row = 2'(tr);
    c.cell_u = 4'(cu);
    c.cell_v = 4'(cv);
    c.amp_raw = 16'(amp);
    c.offset_a_raw = 16'(oa);
    c.offset_b_raw = 16'(ob);
    c.spread_a_raw = 16'(sa);
    c.spread_b_raw = 16'(sbr);
    return c;
  endfunction

  function automatic splat_cmd_t mk_other(logic [1:0] m, int x, int y);
    splat_cmd_t c;
    c = '{default: '0};
    c.mode = m;
    c.read_x = 9'(x);
    c.read_y = 9'(y);
    return c;
  endfunction

  task automatic send_defaults();
    mode <= gss_pkg::MODE_SPLAT;
    tile_col <= '0;
    tile_row <= '0;
    cell_u <= '0;
    cell_v <= '0;
    amp_raw <= '0;
    offset_a_raw <= '0;
    offset_b_raw <= '0;
    spread_a_raw <= '0;
    spread_b_raw <= '0;
    read_x <= '0;
    read_y <= '0;
  endtask

  task automatic send(splat_cmd_t c);
    mode <= c.mode;
    tile_col <= c.tile_col;
    tile_row <= c.tile_row;
    cell_u <= c.cell_u;
    cell_v <= c.cell_v;
    amp_raw <= c.amp_raw;
    offset_a_raw <= c.offset_a_raw;
    offset_b_raw <= c.offset_b_raw;
    spread_a_raw <= c.spread_a_raw;
    spread_b_raw <= c.spread_b_raw;
    read_x <= c.read_x;
    read_y <= c.read_y;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note(c);
    n_sent++;
    if (c.mode == gss_pkg::MODE_SPLAT) begin
      last_x = int'(c.tile_col) * 128 + int'(c.cell_u) * 8 + int'(c.offset_b_raw >> 13);
      last_y = int'(c.tile_row) * 128 + int'(c.cell_v) * 8 + int'(c.offset_a_raw >> 13);
    end
  endtask

  // Often no gap, else mostly short gaps and a few long ones; none at all while no_idle is set.
  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = 0;
    if (!no_idle) begin
      if (r >= 90) n = $urandom_range(20, 200);
      else if (r >= 50) n = $urandom_range(1, 3);
    end
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() > 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_regs(int w, int h, int ag, int dg);
    logic [15:0] vals [4];
    vals = '{16'(w), 16'(h), 16'(ag), 16'(dg)};
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_reg(2'(i), vals[i]);
    end
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic splat_cmd_t rand_cmd(int cap);
    splat_cmd_t c;
    int r;
    int pick;
    c = mk_other(gss_pkg::MODE_READ, $urandom_range(0, 511), $urandom_range(0, 511));
    c.tile_col = 2'($urandom);
    c.tile_row = 2'($urandom);
    c.cell_u = 4'($urandom);
    c.cell_v = 4'($urandom);
    c.amp_raw = 16'($urandom);
    c.offset_a_raw = 16'($urandom);
    c.offset_b_raw = 16'($urandom);
    c.spread_a_raw = 16'($urandom);
    c.spread_b_raw = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 42) begin
      c.mode = gss_pkg::MODE_SPLAT;
      if ($urandom_range(0, 4) == 0) c.amp_raw = 16'($urandom_range(2800, 3800));
      // Keep most windows small; a rare full-range spread gives the widest one.
      pick = $urandom_range(0, 99);
      if (pick >= 2) begin
        c.spread_a_raw = (pick < 8) ? 16'd0 : 16'($urandom_range(0, cap));
        c.spread_b_raw = (pick < 12) ? 16'd0 : 16'($urandom_range(0, cap));
      end
    end else if (r < 95) begin
      c.mode = gss_pkg::MODE_READ;
      if ($urandom_range(0, 9) < 6) begin
        c.read_x = 9'(last_x + $urandom_range(0, 8) - 4);
        c.read_y = 9'(last_y + $urandom_range(0, 8) - 4);
      end
    end else begin
      c.mode = MODE_UNUSED;
    end
    return c;
  endfunction

  task automatic run_random(int count, int cap);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      send(rand_cmd(cap));
      // Hold off once per phase until every outstanding result is back.
      if (i == count / 2) drain();
      else idle_gap();
    end
    drain();
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    cfg_write <= 1'b0;
    cfg_index <= gss_pkg::REG_WIDTH;
    cfg_data <= '0;
    send_defaults();
    n_sent = 0;
    last_x = 0;
    last_y = 0;
    no_idle = 1'b0;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: corners, threshold edges, zero and full spreads, saturation.
    send(mk_splat(0, 0, 0, 0, 65535, 0, 0, 1000, 1000));
    send(mk_other(gss_pkg::MODE_READ, 0, 0));
    send(mk_other(gss_pkg::MODE_READ, 2, 1));
    send(mk_splat(3, 3, 15, 15, 65535, 65535, 65535, 2000, 0));
    send(mk_other(gss_pkg::MODE_READ, 511, 511));
    send(mk_splat(1, 1, 4, 4, 3276, 0, 0, 1000, 1000));
    send(mk_splat(1, 1, 4, 4, 3277, 0, 0, 1000, 1000));
    send(mk_splat(2, 1, 8, 8, 65535, 0, 0, 0, 0));
    send(mk_splat(2, 1, 8, 8, 65535, 0, 0, 0, 2000));
    send(mk_splat(2, 1, 8, 8, 65535, 0, 0, 0, 2000));
    send(mk_other(gss_pkg::MODE_READ, 320, 136));
    send(mk_splat(1, 2, 7, 9, 40000, 32768, 8191, 65535, 65535));
    send(mk_other(gss_pkg::MODE_READ, 184, 328));
    send(mk_other(MODE_UNUSED, 5, 5));
    send(mk_other(gss_pkg::MODE_CLEAR, 0, 0));
    send(mk_other(gss_pkg::MODE_READ, 184, 328));
    drain();

    // Small image with full gains: centers past the edge give empty windows.
    set_regs(128, 256, 65535, 65535);
    send(mk_splat(3, 0, 2, 2, 1000, 0, 0, 100, 100));
    send(mk_splat(0, 3, 2, 2, 1000, 0, 0, 100, 100));
    send(mk_splat(0, 1, 15, 15, 200, 65535, 65535, 170, 170));
    send(mk_other(gss_pkg::MODE_READ, 127, 255));
    run_random(180, 170);

    // Width write with spare upper bits set; zero gains skip every splat.
    set_regs(16'hFE80, 128, 0, 0);
    run_random(40, 65535);

    set_regs(384, 512, 2048, 8192);
    run_random(180, 1365);

    set_regs(512, 512, 4096, 4096);
    run_random(160, 2730);

    repeat (100) @(posedge clk);
    $display("Sent %0d transactions, checked %0d results; %0d splats drawn over %0d pixels.",
             n_sent, sb.n_checked, sb.n_drawn, sb.n_pixels);
    $display("%0d reads returned nonzero pixels; %0d results still pending.",
             sb.n_nonzero_reads, sb.expected_q.size());
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb_gaussian_star_splat: clean");
    end else begin
      $display("tb_gaussian_star_splat: errors");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/gss_pkg.sv
hw/rtl/gss_ctrl.sv
hw/rtl/gss_dp.sv
hw/rtl/gaussian_star_splat.sv
dv/tb_gaussian_star_splat.sv
